// File: src/bacr_pkg.sv
// Shared types, constants and helpers for the arc consistency revise block.
// Used by bacr_unit, binary_arc_consistency_revise and the testbench; depends on nothing.
package bacr_pkg;

  localparam int DOMAIN_SIZE = 32;
  localparam int MATRIX_ROWS = 32;
  localparam int VAL_W       = 5;
  localparam int BITS_W      = 32;

  // values in the universe: below both the domain size and the row count
  localparam int UNIV = (DOMAIN_SIZE < MATRIX_ROWS) ? DOMAIN_SIZE : MATRIX_ROWS;
  localparam logic [VAL_W-1:0]  LAST_IDX  = VAL_W'(UNIV - 1);
  localparam logic [BITS_W-1:0] UNIV_MASK = BITS_W'((64'd1 << UNIV) - 64'd1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_REVISE = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  localparam logic [1:0] ST_UNPRUNED = 2'd0;
  localparam logic [1:0] ST_PRUNED   = 2'd1;
  localparam logic [1:0] ST_FAILURE  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [VAL_W-1:0]  row_index;
    logic [BITS_W-1:0] row_bits;
    logic [VAL_W-1:0]  second_value;
    logic              direction;
    logic [BITS_W-1:0] domain_bits;
    logic [BITS_W-1:0] other_bits;
  } bacr_in_t;

  typedef struct packed {
    logic [BITS_W-1:0] revised_domain;
    logic [1:0]        status;
    logic              satisfied;
  } bacr_out_t;

  // sequencer to support unit
  typedef struct packed {
    logic             clear;
    logic             step;
    logic             dir;
    logic [VAL_W-1:0] idx;
  } bacr_cmd_t;

  function automatic logic in_univ(input logic [VAL_W-1:0] v);
    return {1'b0, v} < (VAL_W+1)'(UNIV);
  endfunction

endpackage

// File: src/binary_arc_consistency_revise.sv
// Arc consistency revise engine over a 32x32 relation bit matrix.
// Depends on bacr_pkg, bacr_ram and bacr_unit.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries a word with
// an operation: load a relation row, revise a domain, or test a value pair.
// Every input word yields exactly one result word on out_valid/out_ready/
// out_data (revised_domain, status, satisfied).
// A revise scans one matrix row per cycle through the RAM read port and the
// support unit, and the block takes no new word until the word in hand has
// reached the output register.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next word is accepted while it waits. If the
// receiver stalls and a second result is ready, the sequencer holds it
// until the output register frees up.
// Reset (rst_n low, synchronous) marks every row empty, so no pair is
// allowed; rows read back as zero until loaded. No clearing pass is needed.
module binary_arc_consistency_revise (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bacr_pkg::bacr_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bacr_pkg::bacr_out_t  out_data
);
  import bacr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t              state_r;
  bacr_in_t            item_r;
  logic [VAL_W-1:0]    cnt_r;
  logic                rd_vld_r;
  logic [VAL_W-1:0]    rd_idx_r;
  logic                row_live_r;
  logic                sat_r;
  logic                out_valid_r;
  bacr_out_t           out_data_r;
  logic [MATRIX_ROWS-1:0] row_valid_r;

  logic                accept;
  logic                last;
  logic                out_load;
  logic                ram_we;
  logic [BITS_W-1:0]   rdata;
  logic [BITS_W-1:0]   eff_row;
  logic [BITS_W-1:0]   kept;
  bacr_cmd_t           cmd;
  bacr_out_t           result;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ram_we   = accept && (in_data.operation == OP_LOAD) && in_univ(in_data.row_index);
  assign last     = (item_r.operation == OP_TEST) || (cnt_r == LAST_IDX);
  assign eff_row  = row_live_r ? rdata : '0;
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  bacr_ram #(
    .WIDTH(BITS_W),
    .DEPTH(MATRIX_ROWS)
  ) u_matrix (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_data.row_index),
    .wdata(in_data.row_bits & UNIV_MASK),
    .re   (state_r == S_SCAN),
    .raddr(cnt_r),
    .rdata(rdata)
  );

  always_comb begin
    cmd.clear = accept;
    cmd.step  = rd_vld_r && (item_r.operation == OP_REVISE);
    cmd.dir   = item_r.direction;
    cmd.idx   = rd_idx_r;
  end

  bacr_unit u_unit (
    .clk   (clk),
    .cmd   (cmd),
    .row   (eff_row),
    .domain(item_r.domain_bits),
    .other (item_r.other_bits),
    .kept  (kept)
  );

  always_comb begin
    result = '0;
    case (item_r.operation)
      OP_REVISE: begin
        result.revised_domain = item_r.domain_bits;
        if (kept == item_r.domain_bits) begin
          result.status = ST_UNPRUNED;
        end else if (kept == '0) begin
          result.status = ST_FAILURE;
        end else begin
          result.status         = ST_PRUNED;
          result.revised_domain = kept;
        end
      end
      OP_TEST: begin
        result.satisfied = sat_r;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      row_valid_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= (state_r == S_SCAN);
      if (ram_we) begin
        row_valid_r[in_data.row_index] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            if (in_data.operation == OP_REVISE) begin
              cnt_r   <= '0;
              state_r <= S_SCAN;
            end else if (in_data.operation == OP_TEST) begin
              cnt_r   <= in_data.row_index;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          rd_idx_r   <= cnt_r;
          row_live_r <= row_valid_r[cnt_r];
          if (last) begin
            state_r <= S_DRAIN;
          end else begin
            cnt_r <= cnt_r + VAL_W'(1);
          end
        end
        S_DRAIN: begin
          // last row lands in the unit this cycle
          sat_r   <= in_univ(item_r.second_value) && eff_row[item_r.second_value];
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_load) begin
            out_data_r <= result;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("block still ready after taking a word");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && !out_valid_r |=> out_valid_r)
    else $error("finished result not moved to output register");

  a_pruned_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_PRUNED)
      |-> (out_data_r.revised_domain != '0) && !out_data_r.satisfied)
    else $error("pruned result with empty domain or stray pair answer");

  a_outside_load_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.operation == OP_LOAD) && !in_univ(in_data.row_index)
      |=> $stable(row_valid_r))
    else $error("row outside the universe was marked loaded");

endmodule

// File: src/bacr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bacr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/bacr_unit.sv
// Support unit: folds one relation row per cycle, while cmd.step is set, into the kept-value set.
// Depends on bacr_pkg.
module bacr_unit (
  input  logic                       clk,
  input  bacr_pkg::bacr_cmd_t        cmd,
  input  logic [bacr_pkg::BITS_W-1:0] row,
  input  logic [bacr_pkg::BITS_W-1:0] domain,
  input  logic [bacr_pkg::BITS_W-1:0] other,
  output logic [bacr_pkg::BITS_W-1:0] kept
);
  import bacr_pkg::*;

  logic [BITS_W-1:0] kept_r;
  logic [BITS_W-1:0] kept_nxt;

  always_comb begin
    kept_nxt = kept_r;
    if (cmd.clear) begin
      kept_nxt = '0;
    end else if (cmd.step) begin
      if (!cmd.dir) begin
        // row idx lists partners of first value idx
        if (domain[cmd.idx] && (|(row & other))) begin
          kept_nxt[cmd.idx] = 1'b1;
        end
      end else if (other[cmd.idx]) begin
        // row idx supports every second value it allows
        kept_nxt = kept_r | (row & domain);
      end
    end
  end

  always_ff @(posedge clk) begin
    kept_r <= kept_nxt;
  end

  assign kept = kept_r;

endmodule

// File: sim/binary_arc_consistency_revise_tb.sv
// Testbench for binary_arc_consistency_revise: directed and random load, revise and pair test
// words, each result word checked field by field against an in-bench predictor of the matrix.
// Depends on bacr_pkg and the binary_arc_consistency_revise RTL.
module binary_arc_consistency_revise_tb;
  import bacr_pkg::*;

  localparam int UNIVERSE    = (DOMAIN_SIZE < MATRIX_ROWS) ? DOMAIN_SIZE : MATRIX_ROWS;
  localparam logic [BITS_W-1:0] VALUE_MASK =
    (UNIVERSE >= BITS_W) ? '1 : BITS_W'((64'd1 << UNIVERSE) - 64'd1);
  localparam int RANDOM_WORDS = 1400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 50;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    bacr_in_t word;
    logic     drain_first;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  bacr_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bacr_out_t out_data;

  pending_t    pending_words[$];
  bacr_out_t   awaited_results[$];
  bacr_out_t   want;
  logic [BITS_W-1:0] allowed_rows [MATRIX_ROWS] = '{default: '0};

  int errors = 0;
  int send_gap = 0, send_burst = 0, stall_left = 0, stall_burst = 0;
  int quiet_cycles = 0;
  int n_load = 0, n_revise = 0, n_test = 0, n_other = 0;
  int n_pruned = 0, n_failure = 0, n_sat = 0;

  binary_arc_consistency_revise dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // first-variable values whose row allows second value x
  function automatic logic [BITS_W-1:0] column_of(input int x);
    logic [BITS_W-1:0] col;
    col = '0;
    for (int y = 0; y < MATRIX_ROWS; y++) begin
      if (y < UNIVERSE && allowed_rows[y][x]) col[y] = 1'b1;
    end
    return col;
  endfunction

  function automatic bacr_out_t predict_result(input bacr_in_t w);
    bacr_out_t         r;
    logic [BITS_W-1:0] kept, partners;
    r = '0;
    kept = '0;
    case (w.operation)
      OP_LOAD: begin
        if (w.row_index < UNIVERSE) allowed_rows[w.row_index] = w.row_bits & VALUE_MASK;
      end
      OP_TEST: begin
        if (w.row_index < UNIVERSE && w.second_value < UNIVERSE)
          r.satisfied = allowed_rows[w.row_index][w.second_value];
      end
      OP_REVISE: begin
        for (int x = 0; x < BITS_W; x++) begin
          if (w.domain_bits[x] && x < UNIVERSE) begin
            partners = w.direction ? column_of(x) : allowed_rows[x];
            if ((partners & w.other_bits) != '0) kept[x] = 1'b1;
          end
        end
        // unpruned wins over failure, so an empty domain stays unpruned
        if (kept == w.domain_bits) begin
          r.status = ST_UNPRUNED;
          r.revised_domain = w.domain_bits;
        end else if (kept == '0) begin
          r.status = ST_FAILURE;
          r.revised_domain = w.domain_bits;
        end else begin
          r.status = ST_PRUNED;
          r.revised_domain = kept;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // densities from empty through single bit to full
  function automatic logic [BITS_W-1:0] shaped_bits();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return BITS_W'(1) << $urandom_range(0, BITS_W - 1);
      3, 4:    return $urandom & $urandom & $urandom;
      5:       return $urandom & $urandom & $urandom & $urandom;
      6:       return $urandom & $urandom;
      7:       return ~($urandom & $urandom);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [1:0] op, input int row, input logic [BITS_W-1:0] bits,
                           input int second, input logic dir, input logic [BITS_W-1:0] dom,
                           input logic [BITS_W-1:0] other, input logic drain);
    pending_t p;
    p.word.operation    = op;
    p.word.row_index    = VAL_W'(row);
    p.word.row_bits     = bits;
    p.word.second_value = VAL_W'(second);
    p.word.direction    = dir;
    p.word.domain_bits  = dom;
    p.word.other_bits   = other;
    p.drain_first       = drain;
    pending_words.push_back(p);
  endtask

  task automatic flag_mismatch(input string what, input logic [BITS_W-1:0] got,
                               input logic [BITS_W-1:0] wanted);
    errors++;
    $display("mismatch %0d: %s got %h want %h", errors, what, got, wanted);
  endtask

  // driver: hold the word until taken, then idle for a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_words.delete(0);
        send_gap = pick_gap(send_burst);
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   !(pending_words[0].drain_first &&
                     (awaited_results.size() != 0 || (in_valid && in_ready)))) begin
        in_valid <= 1'b1;
        in_data  <= pending_words[0].word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) stall_left = pick_gap(stall_burst);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted input word, check each accepted result word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_result(in_data));
        case (in_data.operation)
          OP_LOAD:   n_load++;
          OP_REVISE: n_revise++;
          OP_TEST:   n_test++;
          default:   n_other++;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("unexpected result word, revised_domain",
                        out_data.revised_domain, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.revised_domain !== want.revised_domain)
            flag_mismatch("revised_domain", out_data.revised_domain, want.revised_domain);
          if (out_data.status !== want.status)
            flag_mismatch("status", BITS_W'(out_data.status), BITS_W'(want.status));
          if (out_data.satisfied !== want.satisfied)
            flag_mismatch("satisfied", BITS_W'(out_data.satisfied), BITS_W'(want.satisfied));
          if (want.status == ST_PRUNED) n_pruned++;
          if (want.status == ST_FAILURE) n_failure++;
          if (want.satisfied) n_sat++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("** binary_arc_consistency_revise: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pending_t p;
    int       r;
    int       remaining;

    // empty matrix after reset
    push_word(OP_TEST, 0, $urandom, 0, 1'b0, $urandom, $urandom, 1'b0);
    push_word(OP_TEST, 31, $urandom, 31, 1'b1, $urandom, $urandom, 1'b0);
    push_word(OP_REVISE, 0, '0, 0, 1'b0, '1, '1, 1'b0);
    push_word(OP_REVISE, 31, '1, 31, 1'b1, '1, '1, 1'b0);
    // empty domain stays unpruned
    push_word(OP_REVISE, 0, '0, 0, 1'b0, '0, '1, 1'b0);
    push_word(OP_LOAD, 0, '1, 0, 1'b0, '0, '0, 1'b0);
    push_word(OP_LOAD, 31, 32'h8000_0001, 31, 1'b1, '1, '1, 1'b0);
    push_word(OP_LOAD, 5, 32'hAAAA_5555, 0, 1'b0, '0, '0, 1'b0);
    push_word(OP_TEST, 0, '0, 31, 1'b0, '0, '0, 1'b1);
    push_word(OP_TEST, 31, '0, 0, 1'b0, '0, '0, 1'b0);
    push_word(OP_TEST, 31, '0, 1, 1'b0, '0, '0, 1'b0);
    push_word(OP_TEST, 5, '0, 0, 1'b1, '0, '0, 1'b0);
    push_word(OP_REVISE, 0, '0, 0, 1'b0, '1, '1, 1'b0);
    push_word(OP_REVISE, 0, '0, 0, 1'b1, '1, 32'h8000_0000, 1'b0);
    push_word(OP_REVISE, 0, '0, 0, 1'b0, 32'h8000_0021, '1, 1'b0);
    // a value whose row is empty loses all support
    push_word(OP_REVISE, 0, '0, 0, 1'b0, 32'h0000_0002, '1, 1'b0);
    push_word(OP_REVISE, 0, '0, 0, 1'b1, '1, '0, 1'b0);
    push_word(OP_REVISE, 0, '0, 0, 1'b1, 32'h0000_0003, 32'h0000_0001, 1'b0);
    push_word(OP_UNUSED, 17, '1, 9, 1'b1, '1, '1, 1'b0);
    push_word(OP_LOAD, 0, '0, 0, 1'b0, '1, '1, 1'b0);
    push_word(OP_TEST, 0, '1, 0, 1'b1, '1, '1, 1'b0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      p.word.row_index    = VAL_W'($urandom_range(0, 31));
      p.word.row_bits     = $urandom;
      p.word.second_value = VAL_W'($urandom_range(0, 31));
      p.word.direction    = 1'($urandom_range(0, 1));
      p.word.domain_bits  = $urandom;
      p.word.other_bits   = $urandom;
      p.drain_first       = (i % 250 == 125);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        p.word.operation = OP_LOAD;
        p.word.row_bits  = shaped_bits();
      end else if (r < 70) begin
        p.word.operation   = OP_REVISE;
        p.word.domain_bits = shaped_bits();
        p.word.other_bits  = shaped_bits();
      end else if (r < 95) begin
        p.word.operation = OP_TEST;
      end else begin
        p.word.operation = OP_UNUSED;
      end
      pending_words.push_back(p);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    remaining = pending_words.size();
    while (remaining != 0 || in_valid) begin
      @(posedge clk);
      remaining = pending_words.size();
    end
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d revises, %0d pair tests, %0d unknown-op words",
             n_load, n_revise, n_test, n_other);
    $display("revise outcomes: %0d pruned, %0d failed, rest unpruned; %0d pairs allowed",
             n_pruned, n_failure, n_sat);
    if (errors == 0) begin
      $display("** binary_arc_consistency_revise: PASSED **");
    end else begin
      $display("** binary_arc_consistency_revise: FAILED **");
    end
    $finish;
  end

endmodule
